// ===== rtl/core/cpr_pkg.sv =====
`timescale 1ns / 1ps

package cpr_pkg;

    // Table sizes
    localparam int VIRTUAL_PAGES = 128;
    localparam int REAL_FRAMES   = 64;

    // Field widths
    localparam int PAGE_W  = 7;
    localparam int FRAME_W = 6;
    localparam int USED_W  = 7;
    localparam int FAULT_W = 32;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [USED_W-1:0]  used_t;
    typedef logic [FAULT_W-1:0] fault_t;

endpackage

// ===== rtl/core/cpr_lookup_if.sv =====
`timescale 1ns / 1ps

// Page reference channel
interface cpr_lookup_if;
    logic              valid;
    logic              ready;
    cpr_pkg::page_t    virtual_page;

    modport source (output valid, output virtual_page, input ready);
    modport sink   (input valid, input virtual_page, output ready);
endinterface

// ===== rtl/core/cpr_result_if.sv =====
`timescale 1ns / 1ps

// Replacement result channel
interface cpr_result_if;
    logic              valid;
    logic              ready;
    logic              hit;
    cpr_pkg::frame_t   frame;
    logic              evicted_valid;
    cpr_pkg::page_t    evicted_page;
    cpr_pkg::fault_t   faults_so_far;

    modport source (output valid, output hit, output frame, output evicted_valid,
                    output evicted_page, output faults_so_far, input ready);
    modport sink   (input valid, input hit, input frame, input evicted_valid,
                    input evicted_page, input faults_so_far, output ready);
endinterface

// ===== rtl/core/cpr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/clock_page_replacement.sv =====
// A hit or a fault with a free frame passes from accept through the look and emit
// states into the result register. A fault with all frames full adds the sweep and
// evict states; the sweep clears set reference bits (0 to 64), one frame per cycle.
// One reference is in flight at a time; the result register frees the output side.
// Reset clears residency and reference bits, the fill count, the hand and the
// fault count at once; the page map and frame owner RAMs are not cleared.
`timescale 1ns / 1ps

module clock_page_replacement (
    input  logic                clk,
    input  logic                rst_n,
    cpr_lookup_if.sink          lookup,
    cpr_result_if.source        result
);

    import cpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_EVICT,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    page_t                      page_reg;
    logic [VIRTUAL_PAGES-1:0]   resident_reg;
    logic [REAL_FRAMES-1:0]     referenced_reg;
    used_t                      used_reg;
    frame_t                     hand_reg;
    fault_t                     fault_reg;

    // Pending result
    logic                       hit_reg;
    frame_t                     frame_reg;
    logic                       ev_valid_reg;
    page_t                      ev_page_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_hit_reg;
    frame_t                     out_frame_reg;
    logic                       out_ev_valid_reg;
    page_t                      out_ev_page_reg;
    fault_t                     out_faults_reg;

    logic                       accept;
    logic                       is_resident;
    logic                       has_free;
    frame_t                     hand_inc;
    frame_t                     map_rdata;
    page_t                      owner_rdata;
    logic                       table_we;
    frame_t                     chosen_frame;
    logic                       owner_re;

    assign accept       = lookup.valid && lookup.ready;
    assign lookup.ready = (state_reg == S_IDLE);
    assign is_resident  = resident_reg[page_reg];
    assign has_free     = (used_reg < USED_W'(REAL_FRAMES));
    assign hand_inc     = (hand_reg == FRAME_W'(REAL_FRAMES - 1)) ? '0 : hand_reg + 1'b1;

    // Table writes: fill of a free frame, or replacement after a sweep
    always_comb
    begin
        table_we     = 1'b0;
        chosen_frame = hand_reg;
        if (state_reg == S_LOOK && !is_resident && has_free)
        begin
            table_we     = 1'b1;
            chosen_frame = used_reg[FRAME_W-1:0];
        end
        else if (state_reg == S_EVICT)
        begin
            table_we = 1'b1;
        end
    end

    assign owner_re = (state_reg == S_SWEEP) && !referenced_reg[hand_reg];

    // Page to frame map, read at accept
    cpr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (VIRTUAL_PAGES)
    ) u_map_ram (
        .clk   (clk),
        .we    (table_we),
        .waddr (page_reg),
        .wdata (chosen_frame),
        .re    (accept),
        .raddr (lookup.virtual_page),
        .rdata (map_rdata)
    );

    // Frame to owning page, read at the frame the hand stops on
    cpr_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (REAL_FRAMES)
    ) u_owner_ram (
        .clk   (clk),
        .we    (table_we),
        .waddr (chosen_frame),
        .wdata (page_reg),
        .re    (owner_re),
        .raddr (hand_reg),
        .rdata (owner_rdata)
    );

    // Sequencer, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            page_reg         <= '0;
            resident_reg     <= '0;
            referenced_reg   <= '0;
            used_reg         <= '0;
            hand_reg         <= '0;
            fault_reg        <= '0;
            hit_reg          <= 1'b0;
            frame_reg        <= '0;
            ev_valid_reg     <= 1'b0;
            ev_page_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_hit_reg      <= 1'b0;
            out_frame_reg    <= '0;
            out_ev_valid_reg <= 1'b0;
            out_ev_page_reg  <= '0;
            out_faults_reg   <= '0;
        end
        else
        begin
            // beat taken downstream; emit reloads the register itself
            if (out_valid_reg && result.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        page_reg  <= lookup.virtual_page;
                        state_reg <= S_LOOK;
                    end
                end

                S_LOOK:
                begin
                    ev_valid_reg <= 1'b0;
                    ev_page_reg  <= '0;
                    if (is_resident)
                    begin
                        hit_reg                   <= 1'b1;
                        frame_reg                 <= map_rdata;
                        referenced_reg[map_rdata] <= 1'b1;
                        state_reg                 <= S_EMIT;
                    end
                    else
                    begin
                        hit_reg <= 1'b0;
                        if (fault_reg != '1)
                        begin
                            fault_reg <= fault_reg + 1'b1;
                        end
                        if (has_free)
                        begin
                            frame_reg                      <= used_reg[FRAME_W-1:0];
                            used_reg                       <= used_reg + 1'b1;
                            resident_reg[page_reg]         <= 1'b1;
                            referenced_reg[used_reg[FRAME_W-1:0]] <= 1'b1;
                            state_reg                      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SWEEP;
                        end
                    end
                end

                // second chance: clear and pass, or stop on a clear bit
                S_SWEEP:
                begin
                    if (referenced_reg[hand_reg])
                    begin
                        referenced_reg[hand_reg] <= 1'b0;
                        hand_reg                 <= hand_inc;
                    end
                    else
                    begin
                        state_reg <= S_EVICT;
                    end
                end

                S_EVICT:
                begin
                    resident_reg[owner_rdata] <= 1'b0;
                    resident_reg[page_reg]    <= 1'b1;
                    referenced_reg[hand_reg]  <= 1'b1;
                    frame_reg                 <= hand_reg;
                    hand_reg                  <= hand_inc;
                    ev_valid_reg              <= 1'b1;
                    ev_page_reg               <= owner_rdata;
                    state_reg                 <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_hit_reg      <= hit_reg;
                        out_frame_reg    <= frame_reg;
                        out_ev_valid_reg <= ev_valid_reg;
                        out_ev_page_reg  <= ev_page_reg;
                        out_faults_reg   <= fault_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.hit           = out_hit_reg;
    assign result.frame         = out_frame_reg;
    assign result.evicted_valid = out_ev_valid_reg;
    assign result.evicted_page  = out_ev_page_reg;
    assign result.faults_so_far = out_faults_reg;

    // Checks
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result beat raised outside emit");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(REAL_FRAMES))
        else $error("frame fill count beyond frame count");

    a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !has_free)
        else $error("sweep while free frames remain");

    a_evict_resident: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |-> resident_reg[owner_rdata] && !is_resident)
        else $error("victim not resident or new page already resident");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOK))
        else $error("accepted beat not looked up");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cpr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int CALM_ITEMS   = 60;
    localparam int RANDOM_ITEMS = 400;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic   hit;
        frame_t frame;
        logic   evicted_valid;
        page_t  evicted_page;
        fault_t faults_so_far;
    } replacement_t;

    // Page table mirror: predicts each replacement and checks it against the block
    class cpr_scoreboard;
        bit           resident [VIRTUAL_PAGES];
        frame_t       page_map [VIRTUAL_PAGES];
        page_t        owner [REAL_FRAMES];
        bit           referenced [REAL_FRAMES];
        int unsigned  frames_filled;
        int unsigned  hand;
        fault_t       faults = '0;
        replacement_t awaited [$];
        int unsigned  errors;

        // Work out the replacement for one accepted page reference
        function void note_lookup(page_t vpage);
            int unsigned  pg;
            int unsigned  fr;
            replacement_t r;
            pg = vpage % VIRTUAL_PAGES;
            r = '0;
            if (resident[pg])
            begin
                r.hit = 1'b1;
                fr = page_map[pg] % REAL_FRAMES;
                referenced[fr] = 1'b1;
            end
            else
            begin
                if (faults != '1)
                    faults = faults + 1;
                if (frames_filled < REAL_FRAMES)
                begin
                    fr = frames_filled;
                    frames_filled++;
                end
                else
                begin
                    // second chance sweep: clear set bits until a clear one turns up
                    for (int n = 0; n < REAL_FRAMES && referenced[hand]; n++)
                    begin
                        referenced[hand] = 1'b0;
                        hand = (hand + 1) % REAL_FRAMES;
                    end
                    fr = hand;
                    r.evicted_valid = 1'b1;
                    r.evicted_page = page_t'(owner[fr] % VIRTUAL_PAGES);
                    resident[r.evicted_page] = 1'b0;
                    hand = (hand + 1) % REAL_FRAMES;
                end
                owner[fr] = page_t'(pg);
                page_map[pg] = frame_t'(fr);
                resident[pg] = 1'b1;
                referenced[fr] = 1'b1;
            end
            r.frame = frame_t'(fr);
            r.faults_so_far = faults;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(replacement_t got);
            replacement_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("hit", 64'(want.hit), 64'(got.hit));
            compare_field("frame", 64'(want.frame), 64'(got.frame));
            compare_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
            compare_field("evicted_page", 64'(want.evicted_page), 64'(got.evicted_page));
            compare_field("faults_so_far", 64'(want.faults_so_far), 64'(got.faults_so_far));
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int unsigned cycles = 0;

    cpr_lookup_if lookup_ch ();
    cpr_result_if result_ch ();

    cpr_scoreboard sb = new();

    clock_page_replacement uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Observe accepted beats on both channels
    always @(posedge clk)
    begin
        replacement_t got;
        if (rst_n)
        begin
            if (lookup_ch.valid && lookup_ch.ready)
                sb.note_lookup(lookup_ch.virtual_page);
            if (result_ch.valid && result_ch.ready)
            begin
                got.hit = result_ch.hit;
                got.frame = result_ch.frame;
                got.evicted_valid = result_ch.evicted_valid;
                got.evicted_page = result_ch.evicted_page;
                got.faults_so_far = result_ch.faults_so_far;
                sb.check_result(got);
            end
        end
    end

    // Result side back-pressure in random bursts
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Present one page reference and hold it until accepted
    task automatic send_page(input page_t vpage);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            lookup_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        lookup_ch.valid <= 1'b1;
        lookup_ch.virtual_page <= vpage;
        do
            @(posedge clk);
        while (!(lookup_ch.valid && lookup_ch.ready));
    endtask

    // Hold off until the block has answered everything in flight
    task automatic drain();
        lookup_ch.valid <= 1'b0;
        // let the monitor note the last accepted beat first
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        page_t       directed [$];
        int unsigned base;
        int unsigned span;
        page_t       vpage;

        calm = 1'b0;
        rst_n <= 1'b0;
        lookup_ch.valid <= 1'b0;
        lookup_ch.virtual_page <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, alternating bit patterns, hits on fresh pages
        directed = '{7'd0, 7'd127, 7'd0, 7'd127, 7'h55, 7'h2A, 7'h55, 7'h2A,
                     7'd1, 7'd64, 7'd126, 7'd63, 7'd1, 7'd64, 7'd0, 7'd127};
        foreach (directed[i])
            send_page(directed[i]);
        drain();

        // Random references drawn mostly from a drifting working set, so the run
        // sees both hit streaks and sweeps after all frames are filled
        base = $urandom_range(0, VIRTUAL_PAGES - 1);
        span = $urandom_range(64, VIRTUAL_PAGES);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (i == RANDOM_ITEMS / 2)
                drain();
            if (i % 40 == 39)
            begin
                base = $urandom_range(0, VIRTUAL_PAGES - 1);
                span = $urandom_range(1, VIRTUAL_PAGES);
            end
            if ($urandom_range(0, 7) == 0)
                vpage = page_t'($urandom_range(0, VIRTUAL_PAGES - 1));
            else
                vpage = page_t'((base + $urandom_range(0, span - 1)) % VIRTUAL_PAGES);
            send_page(vpage);
        end
        lookup_ch.valid <= 1'b0;

        // Wait out the tail, then let any stray beat show itself
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_lookup_if.sv
rtl/core/cpr_result_if.sv
rtl/core/cpr_ram.sv
rtl/core/clock_page_replacement.sv
tb/tb_top.sv
